// File: rtl/sh_mpf_pkg.sv
// shared types, constants and helpers for the material patch forward block
package sh_mpf_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int VAL_W     = 32;
    localparam int MU_W      = 64;
    localparam int TAU_W     = 57;
    localparam int OUT_W     = 48;
    localparam int RHO_Q_W   = 49;

    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_INPUT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHYSICAL_Q_MODE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TAU_SLOPE   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TAU_OFFSET  = 4'd3;

    // smallest center density with a nonzero inverse, about 1e-4 in q16.16
    localparam logic [VAL_W-1:0] RHO_MIN_RAW = 32'd7;

    // pipeline depths
    localparam int MU_LAT    = 3;
    localparam int HARM_LAT  = 3 + MU_W;
    localparam int TAU_LAT   = 2 + TAU_W;
    localparam int TOTAL_LAT = MU_LAT + HARM_LAT;

    typedef struct packed {
        logic             velocity_input;
        logic             physical_q_mode;
        logic [VAL_W-1:0] inv_tau_slope;
        logic [VAL_W-1:0] inv_tau_offset;
    } cfg_t;

    typedef struct packed {
        logic [MU_W-1:0]  mu_horizontal;
        logic [MU_W-1:0]  mu_vertical;
        logic [OUT_W-1:0] tau_average;
        logic [OUT_W-1:0] tau_center_out;
        logic [OUT_W-1:0] inv_density;
        logic             status;
    } res_t;

    function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [OUT_W-1:0] sat48(input logic [TAU_W-1:0] v);
        return (|v[TAU_W-1:OUT_W]) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/sh_material_patch_forward.sv
// top level: material patch forward pipeline with output skid
// One patch enters per cycle when in_ready is high; results leave in order and are held
// back by any output stall. The depth is set by the bit-per-stage long
// division of the harmonic means (64 stages after a 3-stage modulus and 3-stage product);
// relaxation time and inverse density use shorter dividers delayed to match. A skid
// register behind the output keeps one result while out_ready is low; in_ready drops only
// while that skid entry is full. Configuration writes are always taken and must be done
// while no transaction is in flight.
module sh_material_patch_forward (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sh_mpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sh_mpf_pkg::VAL_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [31:0]                       prim_center,
    input  logic [31:0]                       prim_east,
    input  logic [31:0]                       prim_south,
    input  logic [31:0]                       prim_southeast,
    input  logic [31:0]                       dens_center,
    input  logic [31:0]                       dens_east,
    input  logic [31:0]                       dens_south,
    input  logic [31:0]                       dens_southeast,
    input  logic [31:0]                       qual_center,
    input  logic [31:0]                       qual_east,
    input  logic [31:0]                       qual_south,
    input  logic [31:0]                       qual_southeast,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [63:0]                       mu_horizontal,
    output logic [63:0]                       mu_vertical,
    output logic [47:0]                       tau_average,
    output logic [47:0]                       tau_center_out,
    output logic [47:0]                       inv_density,
    output logic                              status
);
    import sh_mpf_pkg::*;

    cfg_t             cfg_reg;
    logic             pipe_en;
    logic [VAL_W-1:0] prim [4];
    logic [VAL_W-1:0] dens [4];
    logic [VAL_W-1:0] qual [4];
    logic [MU_W-1:0]  mu [4];
    logic [3:0]       mu_ok;
    logic [TAU_W-1:0] tau [4];
    logic [3:0]       tau_ok;
    logic [MU_W-1:0]  harm_h;
    logic [MU_W-1:0]  harm_v;
    logic             mu_ok_out;
    logic [TAU_W+1:0] tau_sum;
    logic [OUT_W-1:0] tau_avg_reg;
    logic [OUT_W-1:0] tau_c_reg;
    logic             tau_ok_reg;
    logic [2*OUT_W:0] tau_out;
    logic [RHO_Q_W-1:0] rho_quo;
    logic             rho_small;
    logic [OUT_W:0]   rho_out;
    logic             pipe_valid;
    logic             res_ok;
    res_t             pipe_res;
    res_t             out_reg;
    res_t             skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.velocity_input  <= 1'b1;
            cfg_reg.physical_q_mode <= 1'b0;
            cfg_reg.inv_tau_slope   <= '0;
            cfg_reg.inv_tau_offset  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_VELOCITY_INPUT:  cfg_reg.velocity_input  <= cfg_data[0];
                REG_PHYSICAL_Q_MODE: cfg_reg.physical_q_mode <= cfg_data[0];
                REG_INV_TAU_SLOPE:   cfg_reg.inv_tau_slope   <= cfg_data;
                REG_INV_TAU_OFFSET:  cfg_reg.inv_tau_offset  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pipe_en  = !skid_valid_reg;
    assign in_ready = pipe_en;

    assign prim[0] = prim_center;
    assign prim[1] = prim_east;
    assign prim[2] = prim_south;
    assign prim[3] = prim_southeast;
    assign dens[0] = dens_center;
    assign dens[1] = dens_east;
    assign dens[2] = dens_south;
    assign dens[3] = dens_southeast;
    assign qual[0] = qual_center;
    assign qual[1] = qual_east;
    assign qual[2] = qual_south;
    assign qual[3] = qual_southeast;

    for (genvar c = 0; c < 4; c++)
    begin : g_cell
        sh_mpf_mu u_mu (
            .clk           (clk),
            .en            (pipe_en),
            .velocity_input(cfg_reg.velocity_input),
            .prim          (prim[c]),
            .dens          (dens[c]),
            .mu            (mu[c]),
            .ok            (mu_ok[c])
        );

        sh_mpf_tau u_tau (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (pipe_en),
            .cfg  (cfg_reg),
            .qual (qual[c]),
            .tau  (tau[c]),
            .ok   (tau_ok[c])
        );
    end

    sh_mpf_harm u_harm_h (
        .clk (clk),
        .en  (pipe_en),
        .mu_a(mu[0]),
        .mu_b(mu[1]),
        .mean(harm_h)
    );

    sh_mpf_harm u_harm_v (
        .clk (clk),
        .en  (pipe_en),
        .mu_a(mu[0]),
        .mu_b(mu[2]),
        .mean(harm_v)
    );

    sh_mpf_dly #(
        .W(1),
        .N(HARM_LAT)
    ) u_mu_ok_dly (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (pipe_en),
        .d    (&mu_ok),
        .q    (mu_ok_out)
    );

    assign tau_sum = {2'd0, tau[0]} + {2'd0, tau[1]} + {2'd0, tau[2]} + {2'd0, tau[3]};

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            tau_avg_reg <= sat48(tau_sum[TAU_W+1:2]);
            tau_c_reg   <= sat48(tau[0]);
            tau_ok_reg  <= &tau_ok;
        end
    end

    sh_mpf_dly #(
        .W(2*OUT_W + 1),
        .N(TOTAL_LAT - TAU_LAT - 1)
    ) u_tau_dly (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (pipe_en),
        .d    ({tau_ok_reg, tau_avg_reg, tau_c_reg}),
        .q    (tau_out)
    );

    sh_mpf_div #(
        .DEN_W(VAL_W),
        .Q_W  (RHO_Q_W)
    ) u_rho_div (
        .clk   (clk),
        .en    (pipe_en),
        .rem_in('0),
        .num_in({1'b1, 48'd0}),
        .den_in(dens_center),
        .quo   (rho_quo)
    );

    sh_mpf_dly #(
        .W(1),
        .N(RHO_Q_W)
    ) u_rho_small_dly (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (pipe_en),
        .d    (dens_center < RHO_MIN_RAW),
        .q    (rho_small)
    );

    sh_mpf_dly #(
        .W(OUT_W + 1),
        .N(TOTAL_LAT - RHO_Q_W)
    ) u_rho_dly (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (pipe_en),
        .d    ({rho_small, rho_quo[OUT_W-1:0]}),
        .q    (rho_out)
    );

    sh_mpf_dly #(
        .W(1),
        .N(TOTAL_LAT)
    ) u_valid_dly (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (pipe_en),
        .d    (in_valid),
        .q    (pipe_valid)
    );

    // invalid transactions report zero in every result field and set status
    assign res_ok = mu_ok_out && tau_out[2*OUT_W];

    always_comb
    begin
        pipe_res.mu_horizontal  = res_ok ? harm_h : '0;
        pipe_res.mu_vertical    = res_ok ? harm_v : '0;
        pipe_res.tau_average    = res_ok ? tau_out[2*OUT_W-1:OUT_W] : '0;
        pipe_res.tau_center_out = res_ok ? tau_out[OUT_W-1:0] : '0;
        pipe_res.inv_density    = (res_ok && !rho_out[OUT_W]) ? rho_out[OUT_W-1:0] : '0;
        pipe_res.status         = !res_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_valid;
            end
        end
        else if (pipe_valid && pipe_en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : pipe_res;
        end
        else if (pipe_valid && pipe_en)
        begin
            skid_reg <= pipe_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mu_horizontal  = out_reg.mu_horizontal;
    assign mu_vertical    = out_reg.mu_vertical;
    assign tau_average    = out_reg.tau_average;
    assign tau_center_out = out_reg.tau_center_out;
    assign inv_density    = out_reg.inv_density;
    assign status         = out_reg.status;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while output is empty");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without an output stall");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (mu_horizontal == '0 && mu_vertical == '0
            && tau_average == '0 && tau_center_out == '0 && inv_density == '0))
        else $error("invalid transaction carries nonzero result");
endmodule

// File: rtl/sh_mpf_dly.sv
// delay line with stall enable
module sh_mpf_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] stage_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                stage_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            stage_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign q = stage_reg[N-1];
endmodule

// File: rtl/sh_mpf_div.sv
// pipelined restoring divider, one quotient bit per stage
module sh_mpf_div #(
    parameter int DEN_W = 65,
    parameter int Q_W   = 64
) (
    input  logic             clk,
    input  logic             en,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [Q_W-1:0]   num_in,
    input  logic [DEN_W-1:0] den_in,
    output logic [Q_W-1:0]   quo
);
    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   num_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        logic [DEN_W-1:0] rem_p;
        logic [DEN_W-1:0] den_p;
        logic [Q_W-1:0]   num_p;
        logic [Q_W-1:0]   quo_p;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign rem_p = rem_in;
            assign den_p = den_in;
            assign num_p = num_in;
            assign quo_p = '0;
        end
        else
        begin : g_rest
            assign rem_p = rem_reg[i-1];
            assign den_p = den_reg[i-1];
            assign num_p = num_reg[i-1];
            assign quo_p = quo_reg[i-1];
        end

        assign trial = {rem_p, num_p[Q_W-1]};
        assign diff  = trial - {1'b0, den_p};
        assign ge    = trial >= {1'b0, den_p};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                den_reg[i] <= den_p;
                num_reg[i] <= {num_p[Q_W-2:0], 1'b0};
                quo_reg[i] <= {quo_p[Q_W-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[Q_W-1];
endmodule

// File: rtl/sh_mpf_mu.sv
// per-cell shear modulus, three stages
module sh_mpf_mu (
    input  logic                        clk,
    input  logic                        en,
    input  logic                        velocity_input,
    input  logic [sh_mpf_pkg::VAL_W-1:0] prim,
    input  logic [sh_mpf_pkg::VAL_W-1:0] dens,
    output logic [sh_mpf_pkg::MU_W-1:0]  mu,
    output logic                        ok
);
    import sh_mpf_pkg::*;

    logic [MU_W-1:0]  a_reg;
    logic [VAL_W-1:0] prim1_reg;
    logic             zero1_reg;
    logic [MU_W-1:0]  hi_reg;
    logic [VAL_W-1:0] lo_reg;
    logic [VAL_W-1:0] prim2_reg;
    logic             zero2_reg;
    logic [MU_W-1:0]  lo_prod;
    logic [MU_W-1:0]  mu_next;
    logic [MU_W-1:0]  mu_reg;
    logic             ok_reg;

    assign lo_prod = a_reg[VAL_W-1:0] * prim1_reg;
    assign mu_next = velocity_input ? (hi_reg + {32'd0, lo_reg}) : {32'd0, prim2_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= dens * prim;
            prim1_reg <= prim;
            zero1_reg <= (prim == '0) || (dens == '0);
            hi_reg    <= a_reg[MU_W-1:VAL_W] * prim1_reg;
            lo_reg    <= lo_prod[MU_W-1:VAL_W];
            prim2_reg <= prim1_reg;
            zero2_reg <= zero1_reg;
            mu_reg    <= mu_next;
            ok_reg    <= !zero2_reg && (mu_next != '0);
        end
    end

    assign mu = mu_reg;
    assign ok = ok_reg;
endmodule

// File: rtl/sh_mpf_harm.sv
// harmonic mean 2ab/(a+b): split product then long division
module sh_mpf_harm (
    input  logic                       clk,
    input  logic                       en,
    input  logic [sh_mpf_pkg::MU_W-1:0] mu_a,
    input  logic [sh_mpf_pkg::MU_W-1:0] mu_b,
    output logic [sh_mpf_pkg::MU_W-1:0] mean
);
    import sh_mpf_pkg::*;

    logic [MU_W-1:0]     p00_reg;
    logic [MU_W-1:0]     p01_reg;
    logic [MU_W-1:0]     p10_reg;
    logic [MU_W-1:0]     p11_reg;
    logic [MU_W:0]       sum1_reg;
    logic [MU_W:0]       mid_reg;
    logic [MU_W-1:0]     p00b_reg;
    logic [MU_W-1:0]     p11b_reg;
    logic [MU_W:0]       sum2_reg;
    logic [2*MU_W-1:0]   prod_reg;
    logic [MU_W:0]       sum3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg  <= mu_a[31:0] * mu_b[31:0];
            p01_reg  <= mu_a[31:0] * mu_b[63:32];
            p10_reg  <= mu_a[63:32] * mu_b[31:0];
            p11_reg  <= mu_a[63:32] * mu_b[63:32];
            sum1_reg <= {1'b0, mu_a} + {1'b0, mu_b};
            mid_reg  <= {1'b0, p01_reg} + {1'b0, p10_reg};
            p00b_reg <= p00_reg;
            p11b_reg <= p11_reg;
            sum2_reg <= sum1_reg;
            prod_reg <= {p11b_reg, p00b_reg} + {31'd0, mid_reg, 32'd0};
            sum3_reg <= sum2_reg;
        end
    end

    // quotient fits 64 bits, so the top of 2ab is already below a+b
    sh_mpf_div #(
        .DEN_W(MU_W + 1),
        .Q_W  (MU_W)
    ) u_div (
        .clk   (clk),
        .en    (en),
        .rem_in(prod_reg[2*MU_W-1:MU_W-1]),
        .num_in({prod_reg[MU_W-2:0], 1'b0}),
        .den_in(sum3_reg),
        .quo   (mean)
    );
endmodule

// File: rtl/sh_mpf_tau.sv
// per-cell relaxation time, q24.24 unsaturated
module sh_mpf_tau (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  sh_mpf_pkg::cfg_t             cfg,
    input  logic [sh_mpf_pkg::VAL_W-1:0] qual,
    output logic [sh_mpf_pkg::TAU_W-1:0] tau,
    output logic                         ok
);
    import sh_mpf_pkg::*;

    logic [VAL_W-1:0] q1_reg;
    logic             qzero1_reg;
    logic [MU_W-1:0]  pm_reg;
    logic [47:0]      om_reg;
    logic             sn;
    logic             on;
    logic [MU_W-1:0]  inv;
    logic             bad_next;
    logic [MU_W-1:0]  den_reg;
    logic             phys_reg;
    logic             bad_reg;
    logic             bad_out;

    always_comb
    begin
        sn       = cfg.inv_tau_slope[VAL_W-1] && (pm_reg != '0);
        on       = cfg.inv_tau_offset[VAL_W-1] && (om_reg != '0);
        inv      = '0;
        bad_next = qzero1_reg;
        if (cfg.physical_q_mode)
        begin
            priority if (!sn && !on)
            begin
                inv = pm_reg + {16'd0, om_reg};
            end
            else if (sn && on)
            begin
                bad_next = 1'b1;
            end
            else if (sn)
            begin
                inv = {16'd0, om_reg} - pm_reg;
                if ({16'd0, om_reg} <= pm_reg)
                begin
                    bad_next = 1'b1;
                end
            end
            else
            begin
                inv = pm_reg - {16'd0, om_reg};
                if (pm_reg <= {16'd0, om_reg})
                begin
                    bad_next = 1'b1;
                end
            end
            if (!sn && !on && (pm_reg == '0) && (om_reg == '0))
            begin
                bad_next = 1'b1;
            end
        end
        else
        begin
            inv = {32'd0, q1_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg     <= qual;
            qzero1_reg <= (qual == '0);
            pm_reg     <= mag32(cfg.inv_tau_slope) * qual;
            om_reg     <= {mag32(cfg.inv_tau_offset), 16'd0};
            den_reg    <= inv;
            phys_reg   <= cfg.physical_q_mode;
            bad_reg    <= bad_next;
        end
    end

    // legacy rule divides 2^41, physical rule 2^56
    sh_mpf_div #(
        .DEN_W(MU_W),
        .Q_W  (TAU_W)
    ) u_div (
        .clk   (clk),
        .en    (en),
        .rem_in('0),
        .num_in(phys_reg ? {1'b1, 56'd0} : {15'd0, 1'b1, 41'd0}),
        .den_in(den_reg),
        .quo   (tau)
    );

    sh_mpf_dly #(
        .W(1),
        .N(TAU_W)
    ) u_bad_dly (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .d    (bad_reg),
        .q    (bad_out)
    );

    assign ok = !bad_out;
endmodule

// File: verif/testbench.sv
// self-checking testbench for the material patch forward block
`timescale 1ns / 100ps

module testbench;
    import sh_mpf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd9;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [3:0][31:0] prim;
        logic [3:0][31:0] dens;
        logic [3:0][31:0] qual;
    } patch_t;

    class material_scoreboard;
        cfg_t cfg;
        res_t expected_q[$];
        int   errors;

        function void reset_regs();
            cfg.velocity_input  = 1'b1;
            cfg.physical_q_mode = 1'b0;
            cfg.inv_tau_slope   = '0;
            cfg.inv_tau_offset  = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_VELOCITY_INPUT:  cfg.velocity_input  = data[0];
                REG_PHYSICAL_Q_MODE: cfg.physical_q_mode = data[0];
                REG_INV_TAU_SLOPE:   cfg.inv_tau_slope   = data;
                REG_INV_TAU_OFFSET:  cfg.inv_tau_offset  = data;
                default: ;
            endcase
        endfunction

        function logic [63:0] harmonic_mean(logic [63:0] a, logic [63:0] b);
            logic [128:0] num;
            logic [128:0] den;
            logic [128:0] quo;
            num = 129'(a) * 129'(b) * 129'd2;
            den = 129'(a) + 129'(b);
            quo = num / den;
            return quo[63:0];
        endfunction

        // returns 0 when the cell makes the patch invalid
        function bit cell_modulus(logic [31:0] pr, logic [31:0] dn, output logic [63:0] mu);
            logic [63:0] prod;
            logic [63:0] part_hi;
            logic [63:0] part_lo;
            mu = '0;
            if (pr == 0 || dn == 0)
                return 0;
            if (cfg.velocity_input) begin
                prod    = 64'(dn) * 64'(pr);
                part_hi = 64'(prod[63:32]) * 64'(pr);
                part_lo = 64'(prod[31:0]) * 64'(pr);
                mu      = part_hi + (part_lo >> 32);
            end
            else
                mu = 64'(pr);
            return mu != 0;
        endfunction

        function bit cell_relax(logic [31:0] q, output logic [63:0] tau);
            logic [31:0] slope32;
            logic [31:0] offs32;
            logic [63:0] slope_mag;
            logic [63:0] offs_mag;
            logic [63:0] inv;
            bit          slope_neg;
            bit          offs_neg;
            tau = '0;
            if (q == 0)
                return 0;
            if (!cfg.physical_q_mode) begin
                tau = (64'd1 << 41) / 64'(q);
                return 1;
            end
            slope32   = cfg.inv_tau_slope[31] ? (~cfg.inv_tau_slope + 32'd1)
                                              : cfg.inv_tau_slope;
            offs32    = cfg.inv_tau_offset[31] ? (~cfg.inv_tau_offset + 32'd1)
                                               : cfg.inv_tau_offset;
            slope_mag = 64'(slope32);
            offs_mag  = 64'(offs32);
            slope_mag = slope_mag * 64'(q);
            offs_mag  = offs_mag << 16;
            slope_neg = cfg.inv_tau_slope[31] && slope_mag != 0;
            offs_neg  = cfg.inv_tau_offset[31] && offs_mag != 0;
            if (!slope_neg && !offs_neg)
                inv = slope_mag + offs_mag;
            else if (slope_neg && offs_neg)
                return 0;
            else if (slope_neg) begin
                if (offs_mag <= slope_mag)
                    return 0;
                inv = offs_mag - slope_mag;
            end
            else begin
                if (slope_mag <= offs_mag)
                    return 0;
                inv = slope_mag - offs_mag;
            end
            if (inv == 0)
                return 0;
            tau = (64'd1 << 56) / inv;
            return 1;
        endfunction

        function logic [47:0] clamp48(logic [63:0] v);
            return (v > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
        endfunction

        function void note_patch(patch_t p);
            logic [3:0][63:0] mu;
            logic [3:0][63:0] tau;
            logic [63:0]      tau_sum;
            logic [63:0]      recip;
            bit               ok;
            res_t             r;
            ok = 1;
            for (int c = 0; c < 4; c++) begin
                if (!cell_modulus(p.prim[c], p.dens[c], mu[c]))
                    ok = 0;
                if (!cell_relax(p.qual[c], tau[c]))
                    ok = 0;
            end
            r = '0;
            if (!ok)
                r.status = 1'b1;
            else begin
                r.mu_horizontal  = harmonic_mean(mu[0], mu[1]);
                r.mu_vertical    = harmonic_mean(mu[0], mu[2]);
                tau_sum          = tau[0] + tau[1] + tau[2] + tau[3];
                r.tau_average    = clamp48(tau_sum >> 2);
                r.tau_center_out = clamp48(tau[0]);
                recip            = (64'd1 << 48) / 64'(p.dens[0]);
                r.inv_density    = (p.dens[0] < RHO_MIN_RAW) ? 48'd0 : recip[47:0];
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0) begin
                $error("result with no pending transaction");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.mu_horizontal !== want.mu_horizontal) begin
                $error("mu_horizontal expected %0h got %0h", want.mu_horizontal,
                       got.mu_horizontal);
                errors++;
            end
            if (got.mu_vertical !== want.mu_vertical) begin
                $error("mu_vertical expected %0h got %0h", want.mu_vertical, got.mu_vertical);
                errors++;
            end
            if (got.tau_average !== want.tau_average) begin
                $error("tau_average expected %0h got %0h", want.tau_average, got.tau_average);
                errors++;
            end
            if (got.tau_center_out !== want.tau_center_out) begin
                $error("tau_center_out expected %0h got %0h", want.tau_center_out,
                       got.tau_center_out);
                errors++;
            end
            if (got.inv_density !== want.inv_density) begin
                $error("inv_density expected %0h got %0h", want.inv_density, got.inv_density);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0h got %0h", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    patch_t               patch;
    logic                 out_valid;
    logic                 out_ready;
    res_t                 res;

    material_scoreboard sb;
    bit calm;
    bit hold_req;
    int hold_cnt;
    int quiet_cycles;

    sh_material_patch_forward dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .prim_center    (patch.prim[0]),
        .prim_east      (patch.prim[1]),
        .prim_south     (patch.prim[2]),
        .prim_southeast (patch.prim[3]),
        .dens_center    (patch.dens[0]),
        .dens_east      (patch.dens[1]),
        .dens_south     (patch.dens[2]),
        .dens_southeast (patch.dens[3]),
        .qual_center    (patch.qual[0]),
        .qual_east      (patch.qual[1]),
        .qual_south     (patch.qual[2]),
        .qual_southeast (patch.qual[3]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mu_horizontal  (res.mu_horizontal),
        .mu_vertical    (res.mu_vertical),
        .tau_average    (res.tau_average),
        .tau_center_out (res.tau_center_out),
        .inv_density    (res.inv_density),
        .status         (res.status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 26);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(res);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] rand_field();
        case ($urandom_range(15))
            0:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd1;
            1:       return $urandom_range(3) == 0 ? 32'd0 : $urandom_range(6, 1);
            2, 3, 4: return $urandom_range(32'h0001_0000, 32'h0000_0100);
            5, 6:    return $urandom_range(32'h0100_0000, 32'h0001_0000);
            default: return $urandom() | 32'd1;
        endcase
    endfunction

    function automatic patch_t rand_patch();
        patch_t p;
        for (int c = 0; c < 4; c++) begin
            p.prim[c] = rand_field();
            p.dens[c] = rand_field();
            p.qual[c] = rand_field();
        end
        return p;
    endfunction

    function automatic patch_t flat_patch(logic [31:0] v);
        patch_t p;
        for (int c = 0; c < 4; c++) begin
            p.prim[c] = v;
            p.dens[c] = v;
            p.qual[c] = v;
        end
        return p;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_regs(bit vel, bit phys, logic [31:0] slope, logic [31:0] offs);
        write_reg(REG_VELOCITY_INPUT, {31'd0, vel});
        write_reg(REG_PHYSICAL_Q_MODE, {31'd0, phys});
        write_reg(REG_INV_TAU_SLOPE, slope);
        write_reg(REG_INV_TAU_OFFSET, offs);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_patch(patch_t p);
        while (!calm && $urandom_range(99) < 26) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        patch    <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_patch(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 10) @(posedge clk);
    endtask

    task automatic random_run(int count);
        for (int i = 0; i < count; i++)
            send_patch(rand_patch());
        drain();
    endtask

    initial
    begin
        patch_t p;
        sb = new();
        sb.reset_regs();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        patch     = '0;
        out_ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero fields, tiny density and vanishing modulus
        send_patch(flat_patch(32'hFFFF_FFFF));
        send_patch(flat_patch(32'd1));
        send_patch(flat_patch(32'h0001_0000));
        for (int f = 0; f < 3; f++) begin
            p = flat_patch(32'h0002_0000);
            case (f)
                0: p.prim[3] = '0;
                1: p.dens[1] = '0;
                default: p.qual[2] = '0;
            endcase
            send_patch(p);
        end
        p = flat_patch(32'h0003_0000);
        p.dens[0] = 32'd6;
        send_patch(p);
        p.dens[0] = RHO_MIN_RAW;
        send_patch(p);
        p = flat_patch(32'h0001_0000);
        p.qual[0] = 32'd1;
        p.qual[1] = 32'hFFFF_FFFF;
        send_patch(p);
        drain();

        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        set_regs(1'b0, 1'b1, 32'h0001_0000, 32'h0000_8000);
        send_patch(flat_patch(32'hFFFF_FFFF));
        send_patch(flat_patch(32'd1));
        p = flat_patch(32'd1);
        p.qual = {32'd1, 32'd2, 32'd3, 32'd4};
        send_patch(p);
        drain();

        // back to reset settings: long receiver hold-off so the pipe backs up
        set_regs(1'b1, 1'b0, 32'd0, 32'd0);
        hold_req = 1;
        random_run(90);

        calm = 1;
        random_run(70);
        calm = 0;

        set_regs(1'b0, 1'b0, 32'd0, 32'd0);
        random_run(70);

        set_regs(1'b1, 1'b1, 32'h0000_0100, 32'h0000_0010);
        random_run(70);

        set_regs(1'b0, 1'b1, 32'hFFFF_FF00, 32'h7FFF_FFFF);
        random_run(60);

        set_regs(1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        random_run(40);

        set_regs(1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        random_run(40);

        set_regs(1'b1, 1'b1, $urandom(), $urandom());
        random_run(40);

        set_regs(1'b0, 1'b1, 32'd0, 32'd0);
        random_run(20);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: sim.f
rtl/sh_mpf_pkg.sv
rtl/sh_mpf_dly.sv
rtl/sh_mpf_div.sv
rtl/sh_mpf_mu.sv
rtl/sh_mpf_harm.sv
rtl/sh_mpf_tau.sv
rtl/sh_material_patch_forward.sv
verif/testbench.sv
